@@ design/cad_pkg.sv @@
`default_nettype none
package cad_pkg;

    localparam int ATAN_STEPS = 16;
    localparam logic signed [19:0] CORDIC_GAIN = 20'sd39797;
    localparam logic [19:0] TWO_PI_Q16 = 20'd411775;
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

    localparam logic [1:0] OP_SEED = 2'd0;
    localparam logic [1:0] OP_RUN  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [2:0] REG_A = 3'd0;
    localparam logic [2:0] REG_B = 3'd1;
    localparam logic [2:0] REG_C = 3'd2;
    localparam logic [2:0] REG_D = 3'd3;
    localparam logic [2:0] REG_W = 3'd4;
    localparam logic [2:0] REG_H = 3'd5;

    // controller -> datapath
    typedef struct packed {
        logic       load_seed;   // take start position
        logic       trig_start;  // begin one sine/cosine evaluation
        logic [1:0] trig_sel;    // which of the four evaluations
        logic       upd_x;       // combine x'
        logic       upd_y;       // combine y', then grid
        logic       grid_step;   // not used; the grid divider steps itself
        logic       grid_start;
        logic       mem_rd;      // read cell for increment or opcode read
        logic       mem_inc;     // write incremented cell
        logic       clr_step;    // clearing pass write
        logic       out_load;    // capture result
        logic       out_cell;    // result carries a cell value
    } cad_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic trig_done;
        logic grid_done;
        logic clr_done;
    } cad_sts_t;

    function automatic logic [19:0] atan_q16(input logic [3:0] i);
        case (i)
            4'd0:  atan_q16 = 20'd51472;
            4'd1:  atan_q16 = 20'd30386;
            4'd2:  atan_q16 = 20'd16055;
            4'd3:  atan_q16 = 20'd8150;
            4'd4:  atan_q16 = 20'd4091;
            4'd5:  atan_q16 = 20'd2047;
            4'd6:  atan_q16 = 20'd1024;
            4'd7:  atan_q16 = 20'd512;
            4'd8:  atan_q16 = 20'd256;
            4'd9:  atan_q16 = 20'd128;
            4'd10: atan_q16 = 20'd64;
            4'd11: atan_q16 = 20'd32;
            4'd12: atan_q16 = 20'd16;
            4'd13: atan_q16 = 20'd8;
            4'd14: atan_q16 = 20'd4;
            default: atan_q16 = 20'd2;
        endcase
    endfunction

endpackage
`default_nettype wire

@@ design/cad_cordic.sv @@
`default_nettype none
module cad_cordic
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                start,
    input  wire signed [14:0]  coef,
    input  wire signed [15:0]  pos,
    output logic               done,
    output logic signed [13:0] sin_q12,
    output logic signed [13:0] cos_q12
);
    import cad_pkg::*;

    // start: product, 0: phase, 1: angle and seed, 2..17: rotation, 18: finish
    logic [4:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic signed [30:0] prod_reg;
    logic [15:0]        phase_reg;
    logic signed [19:0] x_reg, y_reg;
    logic signed [20:0] z_reg;
    logic [1:0]         quad_reg;
    logic signed [60:0] turns;
    logic [33:0]        zmul;
    logic signed [19:0] dx, dy, rc, rs;
    logic [3:0]         it;

    assign it = 4'(cnt_reg - 5'd2);
    assign dx = y_reg >>> it;
    assign dy = x_reg >>> it;
    assign turns = 61'(prod_reg) * $signed({1'b0, INV_TWO_PI_Q32})
                   + 61'sd549755813888;
    assign zmul = 34'(phase_reg[13:0]) * 34'(TWO_PI_Q16) + 34'd32768;

    function automatic logic signed [13:0] to_q12(input logic signed [19:0] v);
        logic signed [19:0] r;
        begin
            r = (v + 20'sd8) >>> 4;
            if (r > 20'sd4096)       to_q12 = 14'sd4096;
            else if (r < -20'sd4096) to_q12 = -14'sd4096;
            else                     to_q12 = r[13:0];
        end
    endfunction

    always_comb
    begin
        case (quad_reg)
            2'd0:    begin rc = x_reg;  rs = y_reg;  end
            2'd1:    begin rc = -y_reg; rs = x_reg;  end
            2'd2:    begin rc = -x_reg; rs = -y_reg; end
            default: begin rc = y_reg;  rs = -x_reg; end
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = 5'd0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd18)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            done <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
            done <= busy_reg && cnt_reg == 5'd18;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            prod_reg <= 31'(coef) * 31'(pos);
        else if (busy_reg)
        begin
            if (cnt_reg == 5'd0)
                phase_reg <= turns[55:40];
            else if (cnt_reg == 5'd1)
            begin
                quad_reg <= phase_reg[15:14];
                z_reg <= $signed({3'b000, zmul[33:16]});
                x_reg <= CORDIC_GAIN;
                y_reg <= '0;
            end
            else if (cnt_reg <= 5'd17)
            begin
                if (!z_reg[20])
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - $signed({1'b0, atan_q16(it)});
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + $signed({1'b0, atan_q16(it)});
                end
            end
            else
            begin
                sin_q12 <= to_q12(rs);
                cos_q12 <= to_q12(rc);
            end
        end
    end
endmodule
`default_nettype wire

@@ design/cad_datapath.sv @@
`default_nettype none
module cad_datapath
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int COUNT_BITS = 32
)
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  cad_pkg::cad_cmd_t    cmd,
    output cad_pkg::cad_sts_t    sts,
    input  wire signed [14:0]    coef_a,
    input  wire signed [14:0]    coef_b,
    input  wire signed [14:0]    coef_c,
    input  wire signed [14:0]    coef_d,
    input  wire [9:0]            map_width,
    input  wire [9:0]            map_height,
    input  wire signed [14:0]    start_x,
    input  wire signed [14:0]    start_y,
    input  wire [17:0]           cell_index,
    output logic [31:0]          cell_value,
    output logic signed [14:0]   current_x,
    output logic signed [14:0]   current_y
);
    import cad_pkg::*;

    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int HB = $clog2(MAX_HEIGHT + 1);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    logic signed [15:0] px_reg, py_reg, nx_reg;
    logic signed [13:0] s1_reg, s_t, c_t;
    logic               t_done;
    logic signed [14:0] t_coef;
    logic signed [15:0] t_pos;
    logic [COUNT_BITS-1:0] mem [CELLS];
    logic [COUNT_BITS-1:0] rd_reg;
    logic [AW-1:0]      addr_reg, clr_reg;
    logic               clr_done_reg;
    logic [31:0]        cell_reg;

    cad_cordic u_cordic (
        .clk(clk), .rst_n(rst_n), .start(cmd.trig_start),
        .coef(t_coef), .pos(t_pos), .done(t_done),
        .sin_q12(s_t), .cos_q12(c_t)
    );

    always_comb
    begin
        case (cmd.trig_sel)
            2'd0:    begin t_coef = coef_a; t_pos = py_reg; end
            2'd1:    begin t_coef = coef_a; t_pos = px_reg; end
            2'd2:    begin t_coef = coef_b; t_pos = px_reg; end
            default: begin t_coef = coef_b; t_pos = py_reg; end
        endcase
    end

    function automatic logic signed [15:0] comb_q(input logic signed [13:0] s,
        input logic signed [14:0] k, input logic signed [13:0] c);
        logic signed [31:0] v;
        begin
            v = (32'(s) * 32'sd4096 + 32'(k) * 32'(c) + 32'sd2048) >>> 12;
            if (v > 32'sd16383)       comb_q = 16'sd16383;
            else if (v < -32'sd16384) comb_q = -16'sd16384;
            else                      comb_q = v[15:0];
        end
    endfunction

    // half span 1.05*(4096+|k|); n/20 taken as (n/4)/5, the /5 by reciprocal
    function automatic logic [14:0] span_q(input logic [14:0] a);
        logic [19:0] n;
        logic [35:0] p;
        begin
            n = (20'(a) + 20'd4096) * 20'd21 + 20'd10;
            p = 36'(n[19:2]) * 36'd209716;
            span_q = p[34:20];
        end
    endfunction

    // grid: restoring division, one quotient bit per cycle, both axes
    localparam int NB = 16 + 13;
    logic [WB-1:0] w_c;
    logic [HB-1:0] h_c;
    logic [14:0]   mx_reg, my_reg;
    logic [14:0]   ac, ad;
    logic [NB-1:0] numx_reg, numy_reg;
    logic [NB:0]   remx_reg, remy_reg;
    logic [NB-1:0] qx_reg, qy_reg;
    logic [5:0]    gcnt_reg;
    logic          gbusy_reg, gdone_reg;
    logic [16:0]   offx, offy;
    logic [NB:0]   tx, ty;
    logic [WB-1:0] col;
    logic [HB-1:0] row;
    logic [AW+1:0] idx;

    assign ac = coef_c[14] ? 15'(-coef_c) : 15'(coef_c);
    assign ad = coef_d[14] ? 15'(-coef_d) : 15'(coef_d);
    assign w_c = (map_width == 0) ? WB'(1) :
                 (32'(map_width) > MAX_WIDTH) ? WB'(MAX_WIDTH) : WB'(map_width);
    assign h_c = (map_height == 0) ? HB'(1) :
                 (32'(map_height) > MAX_HEIGHT) ? HB'(MAX_HEIGHT) : HB'(map_height);
    assign offx = 17'(nx_reg) + 17'(mx_reg);
    assign offy = 17'(py_reg) + 17'(my_reg);
    assign tx = {remx_reg[NB-1:0], numx_reg[NB-1]} - {(NB-15)'(0), mx_reg, 1'b0};
    assign ty = {remy_reg[NB-1:0], numy_reg[NB-1]} - {(NB-15)'(0), my_reg, 1'b0};
    assign col = (qx_reg >= NB'(w_c)) ? WB'(w_c - 1'b1) : WB'(qx_reg);
    assign row = (qy_reg >= NB'(h_c)) ? HB'(h_c - 1'b1) : HB'(qy_reg);
    assign idx = (AW+2)'(col) + (AW+2)'(row) * (AW+2)'(w_c);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg <= '0;
            py_reg <= '0;
            gbusy_reg <= 1'b0;
            gdone_reg <= 1'b0;
            gcnt_reg <= '0;
            clr_reg <= '0;
            clr_done_reg <= 1'b0;
        end
        else
        begin
            gdone_reg <= 1'b0;
            if (cmd.load_seed)
            begin
                px_reg <= 16'(start_x);
                py_reg <= 16'(start_y);
            end
            if (cmd.upd_x)
                nx_reg <= comb_q(s1_reg, coef_c, c_t);
            if (cmd.upd_y)
            begin
                px_reg <= nx_reg;
                py_reg <= comb_q(s1_reg, coef_d, c_t);
            end
            if (cmd.grid_start)
            begin
                gbusy_reg <= 1'b1;
                gcnt_reg <= '0;
            end
            else if (gbusy_reg)
            begin
                gcnt_reg <= gcnt_reg + 6'd1;
                if (gcnt_reg == 6'(NB - 1))
                begin
                    gbusy_reg <= 1'b0;
                    gdone_reg <= 1'b1;
                end
            end
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + 1'b1;
                if (32'(clr_reg) == CELLS - 1)
                    clr_done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg <= span_q(ac);
        my_reg <= span_q(ad);
        if (cmd.trig_start && t_done)
            s1_reg <= s1_reg;
        else if (t_done && (cmd.trig_sel == 2'd0 || cmd.trig_sel == 2'd2))
            s1_reg <= s_t;
        if (cmd.grid_start)
        begin
            numx_reg <= offx[16] ? '0 : NB'(offx[15:0]) * NB'(w_c);
            numy_reg <= offy[16] ? '0 : NB'(offy[15:0]) * NB'(h_c);
            remx_reg <= '0;
            remy_reg <= '0;
            qx_reg <= '0;
            qy_reg <= '0;
        end
        else if (gbusy_reg)
        begin
            numx_reg <= numx_reg << 1;
            numy_reg <= numy_reg << 1;
            remx_reg <= tx[NB] ? {remx_reg[NB-1:0], numx_reg[NB-1]} : tx;
            remy_reg <= ty[NB] ? {remy_reg[NB-1:0], numy_reg[NB-1]} : ty;
            qx_reg <= {qx_reg[NB-2:0], ~tx[NB]};
            qy_reg <= {qy_reg[NB-2:0], ~ty[NB]};
        end
    end

    // density store
    logic [AW+1:0] rd_idx;
    logic          rd_ok;
    assign rd_idx = cmd.out_cell ? (AW+2)'(cell_index) : idx;
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
            mem[clr_reg] <= '0;
        else if (cmd.mem_inc && rd_reg != CMAX)
            mem[addr_reg] <= rd_reg + 1'b1;
        if (cmd.mem_rd)
        begin
            addr_reg <= rd_idx[AW-1:0];
            rd_ok <= 32'(rd_idx) < CELLS;
            rd_reg <= mem[rd_idx[AW-1:0]];
        end
        if (cmd.out_load)
        begin
            cell_reg <= (cmd.out_cell && rd_ok) ? 32'(rd_reg) : 32'd0;
            current_x <= px_reg[14:0];
            current_y <= py_reg[14:0];
        end
    end

    assign cell_value = cell_reg;
    assign sts.trig_done = t_done;
    assign sts.grid_done = gdone_reg;
    assign sts.clr_done = clr_done_reg;
endmodule
`default_nettype wire

@@ design/cad_ctrl.sv @@
`default_nettype none
module cad_ctrl
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_ready,
    input  wire [1:0]          opcode,
    input  wire [15:0]         step_count,
    output logic               out_valid,
    input  wire                out_ready,
    output cad_pkg::cad_cmd_t  cmd,
    input  cad_pkg::cad_sts_t  sts
);
    import cad_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_TRIG  = 4'd2;
    localparam logic [3:0] S_TWAIT = 4'd3;
    localparam logic [3:0] S_GRID  = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_INC   = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;
    localparam logic [3:0] S_RDC   = 4'd8;
    localparam logic [3:0] S_RDW   = 4'd9;

    logic [3:0]  state_reg, state_next;
    logic [15:0] left_reg, left_next;
    logic [1:0]  sel_reg, sel_next;
    logic        ov_reg, ov_next;
    logic        cell_reg, cell_next;

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        left_next = left_reg;
        sel_next = sel_reg;
        cell_next = cell_reg;
        ov_next = ov_reg && !out_ready;
        cmd = '0;
        cmd.trig_sel = sel_reg;
        cmd.out_cell = cell_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    cmd.clr_step = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
                if (in_valid && in_ready)
                begin
                    cell_next = 1'b0;
                    case (opcode)
                        OP_SEED:
                        begin
                            cmd.load_seed = 1'b1;
                            state_next = S_OUT;
                        end
                        OP_RUN:
                        begin
                            left_next = step_count;
                            sel_next = 2'd0;
                            state_next = (step_count == 16'd0) ? S_OUT : S_TRIG;
                        end
                        OP_READ:
                        begin
                            // cell index is only held during the accepting beat
                            cmd.mem_rd = 1'b1;
                            cmd.out_cell = 1'b1;
                            cell_next = 1'b1;
                            state_next = S_RDC;
                        end
                        default: state_next = S_OUT;
                    endcase
                end
            S_TRIG:
            begin
                cmd.trig_start = 1'b1;
                state_next = S_TWAIT;
            end
            S_TWAIT:
                if (sts.trig_done)
                begin
                    cmd.upd_x = (sel_reg == 2'd1);
                    cmd.upd_y = (sel_reg == 2'd3);
                    sel_next = sel_reg + 2'd1;
                    state_next = (sel_reg == 2'd3) ? S_GRID : S_TRIG;
                    cmd.grid_start = 1'b0;
                end
            S_GRID:
            begin
                if (sel_reg == 2'd0 && left_reg != 16'd0)
                begin
                    cmd.grid_start = 1'b1;
                    left_next = 16'd0 | left_reg;
                    sel_next = 2'd1;
                end
                else if (sts.grid_done)
                    state_next = S_RD;
            end
            S_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_INC;
            end
            S_INC:
            begin
                cmd.mem_inc = 1'b1;
                left_next = left_reg - 16'd1;
                sel_next = 2'd0;
                state_next = (left_reg == 16'd1) ? S_OUT : S_TRIG;
            end
            S_RDC: state_next = S_RDW;
            S_RDW: state_next = S_OUT;
            S_OUT:
                if (!ov_reg)
                begin
                    cmd.out_load = 1'b1;
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            left_reg <= '0;
            sel_reg <= '0;
            ov_reg <= 1'b0;
            cell_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            left_reg <= left_next;
            sel_reg <= sel_next;
            ov_reg <= ov_next;
            cell_reg <= cell_next;
        end
    end
endmodule
`default_nettype wire

@@ design/clifford_attractor_density.sv @@
`default_nettype none
// Each run step performs four CORDIC passes, a grid division, a read of the
// cell and a write of it.
// One command at a time; a new command is accepted while the result waits.
// After reset a clearing pass writes MAX_WIDTH*MAX_HEIGHT cells, one per
// cycle, before the first command is accepted.
module clifford_attractor_density
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int COUNT_BITS = 32
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    // opcode[1:0], start_x[16:2], start_y[31:17], step_count[47:32],
    // cell_index[65:48], zero[71:66]
    input  wire [71:0]  s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // cell_value[31:0], current_x[46:32], current_y[61:47], zero[63:62]
    output logic [63:0] m_tdata,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [4:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cad_pkg::*;

    logic signed [14:0] a_reg, b_reg, c_reg, d_reg;
    logic [9:0]         w_reg, h_reg;
    logic [2:0]         ra;
    cad_cmd_t           cmd;
    cad_sts_t           sts;
    logic [31:0]        cell_value;
    logic signed [14:0] cx, cy;

    assign pready = 1'b1;
    assign ra = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= 15'sd4096;
            b_reg <= 15'sd4096;
            c_reg <= 15'sd4096;
            d_reg <= 15'sd4096;
            w_reg <= 10'd512;
            h_reg <= 10'd512;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (ra)
                REG_A: a_reg <= pwdata[14:0];
                REG_B: b_reg <= pwdata[14:0];
                REG_C: c_reg <= pwdata[14:0];
                REG_D: d_reg <= pwdata[14:0];
                REG_W: w_reg <= pwdata[9:0];
                REG_H: h_reg <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (ra)
            REG_A: prdata = 32'(unsigned'(a_reg));
            REG_B: prdata = 32'(unsigned'(b_reg));
            REG_C: prdata = 32'(unsigned'(c_reg));
            REG_D: prdata = 32'(unsigned'(d_reg));
            REG_W: prdata = 32'(w_reg);
            REG_H: prdata = 32'(h_reg);
            default: prdata = 32'd0;
        endcase
    end

    cad_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .opcode(s_tdata[1:0]), .step_count(s_tdata[47:32]),
        .out_valid(m_tvalid), .out_ready(m_tready), .cmd(cmd), .sts(sts)
    );

    cad_datapath #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .COUNT_BITS(COUNT_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .coef_a(a_reg), .coef_b(b_reg), .coef_c(c_reg), .coef_d(d_reg),
        .map_width(w_reg), .map_height(h_reg),
        .start_x(s_tdata[16:2]), .start_y(s_tdata[31:17]),
        .cell_index(s_tdata[65:48]),
        .cell_value(cell_value), .current_x(cx), .current_y(cy)
    );

    assign m_tdata = {2'b00, cy, cx, cell_value};
endmodule
`default_nettype wire
